>>> rtl/assert_macros.svh
// assertion macros for the rtl, included by sha256_hash.sv
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sha assertion failed");

// condition that must be followed by a consequence in the next cycle
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha assertion failed");

`else

`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/sha_pkg.sv
// sha-256 package: word type, initial hash values, round constants, sigma functions
// no dependencies
`timescale 1ns / 1ps

package sha_pkg;

    typedef logic [31:0] t_word;

    localparam t_word SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> rtl/sha256_hash.sv
// sha-256 hasher top level: byte intake, padding, schedule memory and round datapath
// depends on sha_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// sha-256 over a byte stream. each input item carries one optional message byte
// (i_byte_present) and an end-of-message mark (i_last); the item marked last
// produces exactly one output item, the 256-bit digest as eight big-endian
// words, after which the hasher starts over for the next message. an item with
// only the last mark hashes whatever came before (the empty message if nothing).
// byte items are accepted back to back. every 64th byte starts a compression
// (a prefetch of the schedule memory in S_LOAD0 and S_LOAD1, 64 rounds at one
// per cycle, a fold of the rounds into the chaining words in S_ADD) during
// which no item is accepted. the last item adds the padding bytes, one per
// cycle (up to 72 when the length spills into a second block), and one or two
// compressions. the rounds read the 16-word schedule memory through its two
// read ports and write an expanded word back in rounds 15 to 62. the digest
// sits in its own output register, so the next message can stream in while it
// waits to be taken; a second digest waits for the first to leave.
module sha256_hash
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word_0,
    output logic [31:0] o_digest_word_1,
    output logic [31:0] o_digest_word_2,
    output logic [31:0] o_digest_word_3,
    output logic [31:0] o_digest_word_4,
    output logic [31:0] o_digest_word_5,
    output logic [31:0] o_digest_word_6,
    output logic [31:0] o_digest_word_7
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD0,
        S_LOAD1,
        S_ROUND,
        S_ADD
    } t_state;

    // control
    t_state      r_state;
    logic [5:0]  r_round;
    logic [5:0]  r_fill;
    logic [63:0] r_bytes;
    logic        r_first;   // next padding byte is the 0x80 marker
    logic        r_pad;     // padding in progress for the current message
    logic        r_len_ok;  // this block has room for the length field
    logic        r_final;   // running compression is the last of the message
    logic        r_o_valid;
    t_word       r_chain [8];
    t_word       r_dig [8];

    // datapath
    logic [23:0] r_acc;     // first three bytes of the word being assembled
    t_word       r_w;       // schedule word of the current round
    t_word       r_wm1;     // schedule word of the previous round
    t_word       r_pa;      // port a read data of the previous cycle
    t_word       r_v [8];   // round variables a..h

    // block buffer and rolling message schedule, one word per entry
    t_word       r_wmem [16];
    t_word       r_rd_a;
    t_word       r_rd_b;

    logic        in_take;
    logic        byte_wr;
    logic [7:0]  wr_byte;
    logic [7:0]  pad_byte;
    logic [7:0]  len_byte;
    logic [63:0] len_bits;
    logic [3:0]  rd_idx;
    logic        rd_direct;
    logic [3:0]  rd_addr_a;
    logic [3:0]  rd_addr_b;
    logic        w_direct;
    t_word       w_exp;
    t_word       n_w;
    logic        mem_we;
    logic [3:0]  mem_wa;
    t_word       mem_wd;
    t_word       t1;
    t_word       t2;
    t_word       sum [8];

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_digest_word_0 = r_dig[0];
    assign o_digest_word_1 = r_dig[1];
    assign o_digest_word_2 = r_dig[2];
    assign o_digest_word_3 = r_dig[3];
    assign o_digest_word_4 = r_dig[4];
    assign o_digest_word_5 = r_dig[5];
    assign o_digest_word_6 = r_dig[6];
    assign o_digest_word_7 = r_dig[7];

    // byte intake: message bytes from the port, padding bytes from the sequencer
    always_comb begin
        in_take  = i_valid && o_ready;
        len_bits = {r_bytes[60:0], 3'b000};
        // big-endian length: position 56 takes the top byte
        len_byte = len_bits[{~r_fill[2:0], 3'b000} +: 8];
        if (r_first) begin
            pad_byte = PAD_MARK;
        end else if (r_len_ok && (r_fill >= LEN_POS)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = '0;
        end
        byte_wr = (in_take && i_byte_present) || (r_state == S_PAD);
        wr_byte = (r_state == S_PAD) ? pad_byte : i_data_byte;
    end

    // schedule prefetch: reads issued now serve the word computed next cycle.
    // for word k, port a fetches w[k-15] and port b fetches w[k] (k < 16) or w[k-7]
    always_comb begin
        unique case (r_state)
            S_LOAD0: begin
                rd_idx    = 4'd0;
                rd_direct = 1'b1;
            end
            S_LOAD1: begin
                rd_idx    = 4'd1;
                rd_direct = 1'b1;
            end
            S_ROUND: begin
                rd_idx    = r_round[3:0] + 4'd2;
                rd_direct = (r_round < 6'd14);
            end
            default: begin
                rd_idx    = 4'd0;
                rd_direct = 1'b1;
            end
        endcase
        rd_addr_a = rd_idx + 4'd1;
        rd_addr_b = rd_direct ? rd_idx : rd_idx + 4'd9;
    end

    // next schedule word from the fetched data and the word two positions back
    always_comb begin
        w_direct = (r_state == S_LOAD1) || (r_round < 6'd15);
        w_exp    = r_pa + small_sig0(r_rd_a) + r_rd_b + small_sig1(r_wm1);
        n_w      = w_direct ? r_rd_b : w_exp;
    end

    // single write port: expanded words during rounds, packed bytes otherwise
    always_comb begin
        if ((r_state == S_ROUND) && (r_round >= 6'd15) && (r_round != LAST_POS)) begin
            mem_we = 1'b1;
            mem_wa = r_round[3:0] + 4'd1;
            mem_wd = w_exp;
        end else if (byte_wr && (r_fill[1:0] == 2'd3)) begin
            mem_we = 1'b1;
            mem_wa = r_fill[5:2];
            mem_wd = {r_acc, wr_byte};
        end else begin
            mem_we = 1'b0;
            mem_wa = r_fill[5:2];
            mem_wd = {r_acc, wr_byte};
        end
    end

    // one compression round
    always_comb begin
        t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + round_k(r_round) + r_w;
        t2 = big_sig0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        for (int j = 0; j < 8; j++) begin
            sum[j] = r_chain[j] + r_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wmem[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_wmem[rd_addr_a];
        r_rd_b <= r_wmem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (byte_wr) begin
            r_acc <= {r_acc[15:0], wr_byte};
        end
        if ((r_state == S_LOAD1) || (r_state == S_ROUND)) begin
            r_w   <= n_w;
            r_wm1 <= r_w;
        end
        r_pa <= r_rd_a;
        if (r_state == S_LOAD1) begin
            r_v <= r_chain;
        end else if (r_state == S_ROUND) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_round   <= '0;
            r_fill    <= '0;
            r_bytes   <= '0;
            r_first   <= 1'b0;
            r_pad     <= 1'b0;
            r_len_ok  <= 1'b0;
            r_final   <= 1'b0;
            r_o_valid <= 1'b0;
            r_chain   <= SHA_IV;
        end else begin
            // a digest taken in the cycle that loads the next one stays valid
            if (r_o_valid && i_ready && !((r_state == S_ADD) && r_final)) begin
                r_o_valid <= 1'b0;
            end
            if (byte_wr) begin
                r_fill <= r_fill + 6'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (i_byte_present) begin
                            r_bytes <= r_bytes + 64'd1;
                        end
                        if (i_last) begin
                            r_first <= 1'b1;
                        end
                        if (i_byte_present && (r_fill == LAST_POS)) begin
                            // block full: compress, then pad if this item ends it
                            r_state <= S_LOAD0;
                            r_pad   <= i_last;
                            r_final <= 1'b0;
                        end else if (i_last) begin
                            r_state <= S_PAD;
                            r_pad   <= 1'b1;
                        end
                    end
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    if (r_fill == LAST_POS) begin
                        r_state  <= S_LOAD0;
                        // the block is last only if the length went into it
                        r_final  <= r_len_ok && !r_first;
                        r_len_ok <= 1'b1;
                    end else if (r_first) begin
                        r_len_ok <= (r_fill < LEN_POS);
                    end
                end
                S_LOAD0: begin
                    r_state <= S_LOAD1;
                end
                S_LOAD1: begin
                    r_state <= S_ROUND;
                    r_round <= '0;
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == LAST_POS) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (!r_final) begin
                        r_chain <= sum;
                        r_state <= r_pad ? S_PAD : S_IDLE;
                    end else if (!r_o_valid || i_ready) begin
                        // digest out, chaining words back to the start values
                        r_dig     <= sum;
                        r_o_valid <= 1'b1;
                        r_chain   <= SHA_IV;
                        r_bytes   <= '0;
                        r_pad     <= 1'b0;
                        r_final   <= 1'b0;
                        r_len_ok  <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // rounds never write an entry that is being fetched in the same cycle
    `SHA_ASSERT(a_sched_no_overlap, i_clk, i_rst_n, (mem_we && (r_state == S_ROUND)) |-> ((mem_wa != rd_addr_a) && (mem_wa != rd_addr_b)))
    // a compression always starts on a block boundary
    `SHA_ASSERT(a_block_aligned, i_clk, i_rst_n, (r_state == S_LOAD0) |-> (r_fill == 6'd0))
    // a final compression only happens while padding
    `SHA_ASSERT(a_final_in_pad, i_clk, i_rst_n, r_final |-> r_pad)
    // once the last block is folded in, the digest is presented
    `SHA_ASSERT_NEXT(a_digest_shown, i_clk, i_rst_n, (r_state == S_ADD) && r_final && (!r_o_valid || i_ready), o_valid && (r_state == S_IDLE))

endmodule

>>> bench/tb_sha256_hash.sv
// testbench for sha256_hash: byte items in, one digest item out per finished message
// depends on rtl/sha256_hash.sv and rtl/sha_pkg.sv; holds its own sha-256 digest model
`timescale 1ns / 1ps

module tb_sha256_hash;

    // round constants and initial chaining words of sha-256
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int         LEN_OFFSET = 56;
    localparam int         BLOCK_SIZE = 64;

    // run control
    localparam int RANDOM_ITEMS   = 800;
    localparam int LONG_HOLD      = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 300;

    typedef logic [255:0] t_digest;

    logic        i_clk;
    logic        r_rst_n;
    logic        r_valid;
    logic [7:0]  r_data_byte;
    logic        r_byte_present;
    logic        r_last;
    logic        r_ready;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_digest_word_0;
    logic [31:0] o_digest_word_1;
    logic [31:0] o_digest_word_2;
    logic [31:0] o_digest_word_3;
    logic [31:0] o_digest_word_4;
    logic [31:0] o_digest_word_5;
    logic [31:0] o_digest_word_6;
    logic [31:0] o_digest_word_7;

    // digest model state
    logic [31:0] hash_state [8];
    logic [7:0]  blk_bytes [BLOCK_SIZE];
    int          blk_fill;
    logic [63:0] msg_len;

    t_digest     pending_digests [$];
    int          n_errors;
    int          items_sent;
    int          idle_cycles;

    // idling controls shared by the sender, the receiver and the tests
    bit          send_gaps_on;
    bit          recv_gaps_on;
    bit          long_hold_req;

    sha256_hash u_top (
        .i_clk           (i_clk),
        .i_rst_n         (r_rst_n),
        .i_valid         (r_valid),
        .o_ready         (o_ready),
        .i_data_byte     (r_data_byte),
        .i_byte_present  (r_byte_present),
        .i_last          (r_last),
        .o_valid         (o_valid),
        .i_ready         (r_ready),
        .o_digest_word_0 (o_digest_word_0),
        .o_digest_word_1 (o_digest_word_1),
        .o_digest_word_2 (o_digest_word_2),
        .o_digest_word_3 (o_digest_word_3),
        .o_digest_word_4 (o_digest_word_4),
        .o_digest_word_5 (o_digest_word_5),
        .o_digest_word_6 (o_digest_word_6),
        .o_digest_word_7 (o_digest_word_7)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // digest model
    // ---------------------------------------------------------------

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over blk_bytes, folded into hash_state
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
        logic [31:0] t1, t2, g0, g1;
        for (int r = 0; r < 16; r++) begin
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        end
        for (int r = 16; r < 64; r++) begin
            g0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
            g1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + g0 + w[r-7] + g1;
        end
        va = hash_state[0]; vb = hash_state[1]; vc = hash_state[2]; vd = hash_state[3];
        ve = hash_state[4]; vf = hash_state[5]; vg = hash_state[6]; vh = hash_state[7];
        for (int r = 0; r < 64; r++) begin
            t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
                 + ((ve & vf) ^ (~ve & vg)) + ROUND_K[r] + w[r];
            t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
                 + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        hash_state[0] += va; hash_state[1] += vb; hash_state[2] += vc; hash_state[3] += vd;
        hash_state[4] += ve; hash_state[5] += vf; hash_state[6] += vg; hash_state[7] += vh;
    endfunction

    function automatic void restart_message();
        for (int j = 0; j < 8; j++) hash_state[j] = START_HASH[j];
        blk_fill = 0;
        msg_len  = '0;
    endfunction

    // one accepted item: append the byte, and on the last mark pad and queue the digest
    function automatic void absorb_item(input logic [7:0] b, input logic p, input logic l);
        logic [63:0] bit_len;
        if (p) begin
            blk_bytes[blk_fill] = b;
            blk_fill++;
            msg_len++;
            if (blk_fill == BLOCK_SIZE) begin
                compress_block();
                blk_fill = 0;
            end
        end
        if (l) begin
            bit_len = msg_len << 3;
            blk_bytes[blk_fill] = PAD_BYTE;
            blk_fill++;
            // length does not fit behind the pad byte: spill into a second block
            if (blk_fill > LEN_OFFSET) begin
                while (blk_fill < BLOCK_SIZE) begin
                    blk_bytes[blk_fill] = 8'h00;
                    blk_fill++;
                end
                compress_block();
                blk_fill = 0;
            end
            while (blk_fill < LEN_OFFSET) begin
                blk_bytes[blk_fill] = 8'h00;
                blk_fill++;
            end
            for (int j = 0; j < 8; j++) blk_bytes[LEN_OFFSET + j] = bit_len[63 - 8*j -: 8];
            compress_block();
            pending_digests.push_back({hash_state[0], hash_state[1], hash_state[2],
                                       hash_state[3], hash_state[4], hash_state[5],
                                       hash_state[6], hash_state[7]});
            restart_message();
        end
    endfunction

    // ---------------------------------------------------------------
    // sender, receiver, checker, watchdog
    // ---------------------------------------------------------------

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one item at a falling edge and hold it until the block takes it
    task automatic send_item(input logic [7:0] b, input logic p, input logic l);
        int gap;
        gap = send_gaps_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            r_valid <= 1'b0;
        end
        @(negedge i_clk);
        r_valid        <= 1'b1;
        r_data_byte    <= b;
        r_byte_present <= p;
        r_last         <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_item(b, p, l);
        items_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        r_valid <= 1'b0;
    endtask

    // one message of n random bytes; the end mark rides on the final byte or
    // on a separate finish-only item, with the odd ignored item mixed in if allow_noise
    task automatic send_message(input int n, input bit allow_noise);
        bit mark_on_byte;
        mark_on_byte = (n > 0) && $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            if (allow_noise && $urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, mark_on_byte && (i == n - 1));
        end
        if (!mark_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // receiver: always ready, random ready gaps, or one long hold when a test asks for it
    initial begin : recv_drive
        int gap;
        r_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                r_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (!recv_gaps_on) begin
                r_ready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    r_ready <= 1'b1;
                end else begin
                    r_ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    // each digest item is compared word by word with the oldest expected digest
    always @(posedge i_clk) begin : digest_check
        t_digest want;
        t_digest got;
        if (r_rst_n && o_valid && r_ready) begin
            got = {o_digest_word_0, o_digest_word_1, o_digest_word_2, o_digest_word_3,
                   o_digest_word_4, o_digest_word_5, o_digest_word_6, o_digest_word_7};
            if (pending_digests.size() == 0) begin
                $error("unexpected digest item %h", got);
                n_errors++;
            end else begin
                want = pending_digests.pop_front();
                for (int k = 0; k < 8; k++) begin
                    if (got[255 - 32*k -: 32] !== want[255 - 32*k -: 32]) begin
                        $error("digest_word_%0d expected %h actual %h",
                               k, want[255 - 32*k -: 32], got[255 - 32*k -: 32]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // watchdog: too many cycles in a row with no item moving on either side
    always @(posedge i_clk) begin
        if ((r_valid && o_ready) || (o_valid && r_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // finish-only item with nothing before it
    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    // the "abc" vector, end mark together with the final byte
    task automatic test_known_vector();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    // one-byte messages at both ends of the byte range
    task automatic test_byte_extremes();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
    endtask

    // items with neither byte nor mark must leave the message untouched
    task automatic test_ignored_items();
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h3c, 1'b1, 1'b1);
    endtask

    // end mark on an item that carries no byte, after some bytes
    task automatic test_finish_only();
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hfe, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
    endtask

    // random messages, weighted to short ones and to the padding boundaries
    task automatic test_random_messages();
        int boundary_len [11] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};
        int start_items;
        int r;
        int n;
        start_items = items_sent;
        while ((items_sent - start_items) < RANDOM_ITEMS) begin
            send_gaps_on = ($urandom_range(0, 3) != 0);
            recv_gaps_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 75) n = $urandom_range(0, 12);
            else if (r < 92) n = boundary_len[$urandom_range(0, 10)];
            else n = $urandom_range(13, 150);
            send_message(n, 1'b1);
        end
    endtask

    // receiver stalls for a long stretch while short messages keep coming, so the
    // digest register fills, the next digest waits in S_ADD and the input stalls
    task automatic test_output_backpressure();
        send_gaps_on  = 1'b0;
        recv_gaps_on  = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_message($urandom_range(0, 4), 1'b0);
    endtask

    initial begin
        r_rst_n        = 1'b0;
        r_valid        = 1'b0;
        r_data_byte    = 8'h00;
        r_byte_present = 1'b0;
        r_last         = 1'b0;
        send_gaps_on   = 1'b1;
        recv_gaps_on   = 1'b1;
        long_hold_req  = 1'b0;
        n_errors       = 0;
        items_sent     = 0;
        idle_cycles    = 0;
        restart_message();

        // synchronous reset, released at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        r_rst_n <= 1'b1;

        test_empty_message();
        test_known_vector();
        test_byte_extremes();
        test_ignored_items();
        test_finish_only();
        test_output_backpressure();
        test_random_messages();

        // all stimulus taken: drain the expected digests, then watch for strays
        drop_valid();
        while (pending_digests.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_digests.size() != 0) begin
            $error("%0d expected digests never arrived", pending_digests.size());
            n_errors++;
        end

        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sha256_hash.f
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha256_hash.sv
bench/tb_sha256_hash.sv
